FILE: rtl/ssh_pkg.sv
`timescale 1ns / 1ps
// Shared constants, entry layout and sequencer states for the space-saving
// heavy-hitter block. No dependencies.
package ssh_pkg;

  localparam int CAPACITY = 64;
  localparam int KEY_BITS = 32;
  localparam int POS_W    = $clog2(CAPACITY);
  localparam int USED_W   = $clog2(CAPACITY + 1);
  localparam int CNT_W    = 32;
  localparam int CFG_W    = 7;

  localparam logic [CNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic [CNT_W-1:0]    count;
    logic [KEY_BITS-1:0] key;
    logic [POS_W-1:0]    slot;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [10:0] {
    S_IDLE   = 11'b000_0000_0001,
    S_LOOK   = 11'b000_0000_0010,
    S_HIT    = 11'b000_0000_0100,
    S_UP     = 11'b000_0000_1000,
    S_SWAP   = 11'b000_0001_0000,
    S_SWAP2  = 11'b000_0010_0000,
    S_BACK   = 11'b000_0100_0000,
    S_MISS   = 11'b000_1000_0000,
    S_NEWCHK = 11'b001_0000_0000,
    S_EVICT  = 11'b010_0000_0000,
    S_FIN    = 11'b100_0000_0000
  } state_t;

endpackage

FILE: rtl/ssh_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: key input, result output, config write.
// Depends on ssh_pkg.
interface ssh_key_if import ssh_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KEY_BITS-1:0] key;
  modport source (output valid, output key, input ready);
  modport sink   (input valid, input key, output ready);
endinterface

interface ssh_res_if import ssh_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              evicted;
  logic [POS_W-1:0]  evicted_slot;
  logic [31:0]       evicted_key;
  logic [POS_W-1:0]  word_slot;
  logic [CNT_W-1:0]  word_count;
  logic [USED_W-1:0] occupied;
  logic [31:0]       stream_total;
  modport source (output valid, output evicted, output evicted_slot, output evicted_key,
                  output word_slot, output word_count, output occupied,
                  output stream_total, input ready);
  modport sink   (input valid, input evicted, input evicted_slot, input evicted_key,
                  input word_slot, input word_count, input occupied,
                  input stream_total, output ready);
endinterface

interface ssh_cfg_if import ssh_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/ssh_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module ssh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: rtl/space_saving_heavy_hitters.sv
`timescale 1ns / 1ps
// Space-saving top-k summary over a stream of 32-bit keys.
// Depends on ssh_pkg, ssh_ifs (channel interfaces) and ssh_ram.
//
// Channels: keys (sink) carries one key per transfer; results (source) carries
// one result per key: eviction flag, evicted slot and key, slot and count of the
// observed key, occupancy and running total. cfg (sink) writes counters_in_use;
// it is always ready and must only be written while the block is idle.
// All entries (count, key, slot) live in one RAM indexed by sorted position,
// with a registered read port; a sequencer walks it one entry per cycle.
// Per key: a lookup scan over the occupied entries up to the match, then an
// update, plus one step per position moved when an incremented entry climbs
// its block or the minimum block is re-found.
// One key is in work at a time; keys.ready is high only while the sequencer
// is idle. The result sits in an output register, so the next key is taken
// while a result waits; a stalled receiver holds the sequencer at its end.
// Reset (rst, synchronous) empties the summary, clears the total and sets
// counters_in_use to 64. The RAM needs no clearing: only entries at occupied
// positions are used.
module space_saving_heavy_hitters import ssh_pkg::*; (
  input logic         clk,
  input logic         rst,
  ssh_cfg_if.sink     cfg,
  ssh_key_if.sink     keys,
  ssh_res_if.source   results
);

  state_t state;

  logic [CFG_W-1:0]    limit_cfg;
  logic [USED_W-1:0]   used;
  logic [31:0]         total;
  logic [POS_W-1:0]    mbs;
  logic [KEY_BITS-1:0] cur_key;
  logic [POS_W-1:0]    idx, p, q, m;
  entry_t              ep, hold;
  logic                res_ev;
  logic [POS_W-1:0]    res_evslot, res_slot;
  logic [31:0]         res_evkey;
  logic [CNT_W-1:0]    res_count;

  logic                we;
  logic [POS_W-1:0]    waddr, raddr;
  entry_t              wdata, rent;
  logic [ENTRY_W-1:0]  rdata;

  ssh_ram #(.WIDTH(ENTRY_W), .DEPTH(CAPACITY)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  assign rent = entry_t'(rdata);

  logic [USED_W-1:0] limit;
  always_comb begin
    if (limit_cfg == '0) limit = USED_W'(1);
    else if (USED_W'(limit_cfg) > USED_W'(CAPACITY)) limit = USED_W'(CAPACITY);
    else limit = USED_W'(limit_cfg);
  end

  logic [CNT_W-1:0] inc_src, cnt_plus;
  logic             cnt_sat, m_last, has_room;
  logic [POS_W-1:0] mbs_inc;
  assign inc_src  = (state == S_EVICT) ? rent.count : ep.count;
  assign cnt_sat  = (inc_src == COUNT_MAX);
  assign cnt_plus = inc_src + CNT_W'(1);
  assign m_last   = ((USED_W'(mbs) + USED_W'(1)) == used);
  assign mbs_inc  = (mbs == POS_W'(CAPACITY - 1)) ? mbs : mbs + POS_W'(1);
  assign has_room = (used < limit);

  assign cfg.ready  = 1'b1;
  assign keys.ready = (state == S_IDLE);

  // RAM port control
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    raddr = '0;
    case (state)
      S_LOOK: raddr = idx + POS_W'(1);
      S_HIT: begin
        if (!cnt_sat) begin
          if (p == mbs || p == '0) begin
            we    = 1'b1;
            waddr = p;
            wdata = '{count: cnt_plus, key: ep.key, slot: ep.slot};
            raddr = mbs - POS_W'(1);
          end else begin
            raddr = p - POS_W'(1);
          end
        end
      end
      S_UP:   raddr = q - POS_W'(2);
      S_BACK: raddr = m - POS_W'(2);
      S_SWAP: begin
        we    = 1'b1;
        waddr = q;
        wdata = '{count: res_count, key: ep.key, slot: ep.slot};
      end
      S_SWAP2: begin
        we    = 1'b1;
        waddr = p;
        wdata = hold;
      end
      S_MISS: begin
        raddr = mbs;
        if (has_room) begin
          we    = 1'b1;
          waddr = used[POS_W-1:0];
          wdata = '{count: CNT_W'(1), key: cur_key, slot: used[POS_W-1:0]};
        end
      end
      S_EVICT: begin
        we    = 1'b1;
        waddr = mbs;
        wdata = '{count: cnt_sat ? COUNT_MAX : cnt_plus, key: cur_key, slot: rent.slot};
        raddr = mbs - POS_W'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      limit_cfg     <= CFG_W'(CAPACITY);
      used          <= '0;
      total         <= '0;
      mbs           <= '0;
      results.valid <= 1'b0;
    end else begin
      if (cfg.valid) limit_cfg <= cfg.data;
      if (results.valid && results.ready && state != S_FIN) results.valid <= 1'b0;

      case (state)
        S_IDLE: begin
          if (keys.valid) begin
            cur_key    <= keys.key;
            idx        <= '0;
            res_ev     <= 1'b0;
            res_evslot <= '0;
            res_evkey  <= '0;
            if (total != 32'hFFFF_FFFF) total <= total + 32'd1;
            state <= (used == '0) ? S_MISS : S_LOOK;
          end
        end
        S_LOOK: begin
          if (rent.key == cur_key) begin
            p     <= idx;
            ep    <= rent;
            state <= S_HIT;
          end else if ((USED_W'(idx) + USED_W'(1)) == used) begin
            state <= S_MISS;
          end else begin
            idx <= idx + POS_W'(1);
          end
        end
        S_HIT: begin
          res_slot <= ep.slot;
          if (cnt_sat) begin
            res_count <= COUNT_MAX;
            state     <= S_FIN;
          end else begin
            res_count <= cnt_plus;
            if (p == mbs) begin
              m <= mbs;
              if (!m_last) begin
                mbs   <= mbs_inc;
                state <= S_FIN;
              end else begin
                state <= (mbs == '0) ? S_FIN : S_BACK;
              end
            end else begin
              if (p > mbs) mbs <= mbs_inc;
              q     <= p;
              state <= (p == '0) ? S_FIN : S_UP;
            end
          end
        end
        S_UP: begin
          // entry at q-1 is on the read port
          if (res_count > rent.count) begin
            q    <= q - POS_W'(1);
            hold <= rent;
            if (q == POS_W'(1)) state <= S_SWAP;
          end else begin
            state <= S_SWAP;
          end
        end
        S_SWAP: state <= (q == p) ? S_FIN : S_SWAP2;
        S_SWAP2: state <= S_FIN;
        S_BACK: begin
          // count of position m-1 is on the read port
          if (rent.count == res_count) begin
            m <= m - POS_W'(1);
            if (m == POS_W'(1)) begin
              mbs   <= '0;
              state <= S_FIN;
            end
          end else begin
            mbs   <= m;
            state <= S_FIN;
          end
        end
        S_MISS: begin
          if (has_room) begin
            res_slot  <= used[POS_W-1:0];
            res_count <= CNT_W'(1);
            used      <= used + USED_W'(1);
            if (used == '0) begin
              mbs   <= '0;
              state <= S_FIN;
            end else begin
              state <= S_NEWCHK;
            end
          end else begin
            state <= S_EVICT;
          end
        end
        S_NEWCHK: begin
          if (rent.count > CNT_W'(1)) mbs <= res_slot;
          state <= S_FIN;
        end
        S_EVICT: begin
          res_ev     <= 1'b1;
          res_evslot <= rent.slot;
          res_evkey  <= 32'(rent.key);
          res_slot   <= rent.slot;
          m          <= mbs;
          if (cnt_sat) begin
            res_count <= COUNT_MAX;
            state     <= S_FIN;
          end else begin
            res_count <= cnt_plus;
            if (!m_last) begin
              mbs   <= mbs_inc;
              state <= S_FIN;
            end else begin
              state <= (mbs == '0) ? S_FIN : S_BACK;
            end
          end
        end
        S_FIN: begin
          if (!results.valid || results.ready) begin
            results.valid        <= 1'b1;
            results.evicted      <= res_ev;
            results.evicted_slot <= res_evslot;
            results.evicted_key  <= res_evkey;
            results.word_slot    <= res_slot;
            results.word_count   <= res_count;
            results.occupied     <= used;
            results.stream_total <= total;
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // occupancy never passes the RAM depth
  a_used_cap: assert property (@(posedge clk) disable iff (rst)
    used <= USED_W'(CAPACITY))
    else $error("occupancy above capacity");

  // minimum block start lies inside the occupied range
  a_mbs_range: assert property (@(posedge clk) disable iff (rst)
    (used != '0) |-> (USED_W'(mbs) < used))
    else $error("min block start outside occupied entries");

  // RAM writes only land at occupied positions or the next free one
  a_wr_range: assert property (@(posedge clk) disable iff (rst)
    we |-> (USED_W'(waddr) <= used))
    else $error("write beyond occupied entries");

  // a delivered result always counts at least one item
  a_total: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (results.stream_total != '0 && results.word_count != '0))
    else $error("result with zero total or count");

endmodule
